[sv/rmsm_pkg.sv]
package rmsm_pkg;

  // Fixed-point layout of the offset filter
  localparam int FRAC_BITS  = 20;
  // The mean is scaled up by 2^16 ahead of the square root, giving a Q8 root
  localparam int MEAN_SHIFT = 16;
  // Q8 rms times Q16 gain leaves 24 fraction bits to drop
  localparam int GAIN_SHIFT = 24;

  localparam int RMS_W   = 18;
  localparam int CUR_W   = 20;
  localparam int GAIN_W  = 32;
  localparam int COUNT_W = 16;
  localparam int TAKEN_W = COUNT_W + 1;
  localparam int CFG_W   = GAIN_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [RMS_W-1:0] RMS_MAX     = {RMS_W{1'b1}};
  localparam logic [CUR_W-1:0] CURRENT_MAX = {CUR_W{1'b1}};

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 16'd1480;
  localparam logic [GAIN_W-1:0]  GAIN_RESET         = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 1'b0,
    REG_GAIN         = 1'b1
  } reg_idx_t;

endpackage

[sv/rmsm_root_unit.sv]
module rmsm_root_unit #(
  parameter int SUM_W = 37
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SUM_W-1:0]              dividend,
  input  logic [rmsm_pkg::TAKEN_W-1:0]  divisor,
  output logic                          done,
  output logic [(SUM_W+rmsm_pkg::MEAN_SHIFT+1)/2-1:0] root
);

  localparam int ITER  = (SUM_W + rmsm_pkg::MEAN_SHIFT + 1) / 2;
  localparam int V_W   = 2 * ITER;
  localparam int CMP_W = (ITER + 2 > rmsm_pkg::TAKEN_W + 1) ? ITER + 2 : rmsm_pkg::TAKEN_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_SQRT
  } ustate_t;

  ustate_t                      state_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [SUM_W-1:0]             dvd_r;
  logic [rmsm_pkg::TAKEN_W-1:0] dvs_r;
  logic [CMP_W-1:0]             rem_r;
  logic [V_W-1:0]               v_r;
  logic [ITER-1:0]              root_r;
  logic                         done_r;

  logic [CMP_W-1:0] op_a;
  logic [CMP_W-1:0] op_b;
  logic [CMP_W:0]   diff;
  logic             ge;
  logic [CMP_W-1:0] rem_nxt;
  logic [SUM_W-1:0] quot_nxt;

  // Shared compare-subtract: divide steps and root steps take turns on it
  always_comb begin
    if (state_r == U_SQRT) begin
      op_a = {rem_r[CMP_W-3:0], v_r[V_W-1:V_W-2]};
      op_b = CMP_W'({root_r, 2'b01});
    end else begin
      op_a = {rem_r[CMP_W-2:0], dvd_r[SUM_W-1]};
      op_b = CMP_W'(dvs_r);
    end
    diff     = {1'b0, op_a} - {1'b0, op_b};
    ge       = ~diff[CMP_W];
    rem_nxt  = ge ? diff[CMP_W-1:0] : op_a;
    quot_nxt = {dvd_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == U_SQRT) && (cnt_r == CNT_W'(1));
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            dvd_r   <= dividend;
            dvs_r   <= divisor;
            rem_r   <= '0;
            cnt_r   <= CNT_W'(SUM_W);
            state_r <= U_DIV;
          end
        end
        U_DIV: begin
          dvd_r <= quot_nxt;
          if (cnt_r == CNT_W'(1)) begin
            // quotient complete: scale it and start the root
            v_r     <= V_W'({quot_nxt, {rmsm_pkg::MEAN_SHIFT{1'b0}}});
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNT_W'(ITER);
            state_r <= U_SQRT;
          end else begin
            rem_r <= rem_nxt;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        U_SQRT: begin
          rem_r  <= rem_nxt;
          root_r <= {root_r[ITER-2:0], ge};
          v_r    <= {v_r[V_W-3:0], 2'b00};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= U_IDLE;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[sv/rms_current_meter.sv]
// Channel | Direction | Ports                                    | Transaction
// in      | sink      | in_valid, in_ready, in_adc_sample        | one converter sample
// out     | source    | out_valid, out_ready, out_rms_counts_q8,  | one window result
//         |           | out_current_ma                           |
// cfg     | sink      | cfg_we, cfg_index, cfg_wdata             | one register write
//
// A sample passes through accept, filter step, square and accumulate; in_ready is low meanwhile.
// The last sample of a window then goes on to the root: one
// restoring divide step per sum bit and one root step per result bit on a shared subtractor,
// then the gain multiply and the output load.
// Reset is synchronous; it restores the registers, centres the offset and empties the window.
// The result sits in an output register: the next sample is taken while it waits; only a window
// end waits for the previous result to be taken.
module rms_current_meter #(
  parameter int ADC_BITS     = 10,
  parameter int FILTER_SHIFT = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ADC_BITS-1:0]                in_adc_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rmsm_pkg::RMS_W-1:0]         out_rms_counts_q8,
  output logic [rmsm_pkg::CUR_W-1:0]         out_current_ma,
  input  logic                               cfg_we,
  input  logic [rmsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmsm_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int OFS_W  = ADC_BITS + rmsm_pkg::FRAC_BITS;
  localparam int MAG_W  = ADC_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 2 * ADC_BITS + 17;
  localparam int ROOT_W = (SUM_W + rmsm_pkg::MEAN_SHIFT + 1) / 2;
  localparam int PROD_W = rmsm_pkg::RMS_W + rmsm_pkg::GAIN_W;
  localparam logic [OFS_W-1:0] OFS_RESET = {1'b1, {(OFS_W-1){1'b0}}};
  localparam logic [OFS_W:0]   OFS_HALF  = (OFS_W+1)'(1) << (rmsm_pkg::FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_SQ,
    S_ACC,
    S_ROOT,
    S_MUL,
    S_OUT
  } state_t;

  state_t                             state_r;
  logic [rmsm_pkg::COUNT_W-1:0]       sample_count_r;
  logic [rmsm_pkg::GAIN_W-1:0]        gain_r;
  logic [ADC_BITS-1:0]                sample_r;
  logic [OFS_W-1:0]                   offset_r;
  logic [SQ_W-1:0]                    sq_r;
  logic [SUM_W-1:0]                   sum_r;
  logic [rmsm_pkg::COUNT_W-1:0]       pos_r;
  logic [rmsm_pkg::RMS_W-1:0]         rms_r;
  logic [PROD_W-1:0]                  prod_r;
  logic                               out_valid_r;
  logic [rmsm_pkg::RMS_W-1:0]         out_rms_r;
  logic [rmsm_pkg::CUR_W-1:0]         out_cur_r;

  logic signed [OFS_W:0]              ofs_diff;
  logic signed [OFS_W:0]              ofs_sum;
  logic [OFS_W:0]                     ofs_round;
  logic [MAG_W-1:0]                   rounded;
  logic [MAG_W-1:0]                   sample_ext;
  logic [MAG_W-1:0]                   mag;
  logic [SUM_W-1:0]                   sum_nxt;
  logic [rmsm_pkg::COUNT_W-1:0]       pos_nxt;
  logic [rmsm_pkg::COUNT_W-1:0]       count_eff;
  logic                               window_end;
  logic [rmsm_pkg::TAKEN_W-1:0]       taken;
  logic                               root_start;
  logic                               root_done;
  logic [ROOT_W-1:0]                  root;
  logic [rmsm_pkg::RMS_W-1:0]         rms_sat;
  logic [PROD_W-rmsm_pkg::GAIN_SHIFT-1:0] cur_full;
  logic [rmsm_pkg::CUR_W-1:0]         cur_sat;
  logic                               out_free;

  always_comb begin
    // filter step rounds toward minus infinity
    ofs_diff   = $signed({1'b0, sample_r, {rmsm_pkg::FRAC_BITS{1'b0}}}) -
                 $signed({1'b0, offset_r});
    ofs_sum    = $signed({1'b0, offset_r}) + (ofs_diff >>> FILTER_SHIFT);
    ofs_round  = {1'b0, offset_r} + OFS_HALF;
    rounded    = ofs_round[OFS_W:rmsm_pkg::FRAC_BITS];
    sample_ext = {1'b0, sample_r};
    mag        = (sample_ext >= rounded) ? sample_ext - rounded : rounded - sample_ext;
    sum_nxt    = sum_r + SUM_W'(sq_r);
    pos_nxt    = pos_r + 1'b1;
    count_eff  = (sample_count_r == '0) ? rmsm_pkg::COUNT_W'(1) : sample_count_r;
    window_end = (pos_nxt == '0) || (pos_nxt >= count_eff);
    // a wrapped position means a full 65536-sample window
    taken      = (pos_nxt == '0) ? {1'b1, {rmsm_pkg::COUNT_W{1'b0}}} : {1'b0, pos_nxt};
    root_start = (state_r == S_ACC) && window_end;
    rms_sat    = (root > ROOT_W'(rmsm_pkg::RMS_MAX)) ? rmsm_pkg::RMS_MAX
                                                     : root[rmsm_pkg::RMS_W-1:0];
    cur_full   = prod_r[PROD_W-1:rmsm_pkg::GAIN_SHIFT];
    cur_sat    = (cur_full > (PROD_W-rmsm_pkg::GAIN_SHIFT)'(rmsm_pkg::CURRENT_MAX))
                 ? rmsm_pkg::CURRENT_MAX : cur_full[rmsm_pkg::CUR_W-1:0];
    out_free   = !out_valid_r || out_ready;
  end

  rmsm_root_unit #(
    .SUM_W (SUM_W)
  ) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (sum_nxt),
    .divisor  (taken),
    .done     (root_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= rmsm_pkg::SAMPLE_COUNT_RESET;
      gain_r         <= rmsm_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (rmsm_pkg::reg_idx_t'(cfg_index))
        rmsm_pkg::REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[rmsm_pkg::COUNT_W-1:0];
        rmsm_pkg::REG_GAIN:         gain_r         <= cfg_wdata[rmsm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      offset_r    <= OFS_RESET;
      sum_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= in_adc_sample;
            state_r  <= S_FILT;
          end
        end
        S_FILT: begin
          offset_r <= ofs_sum[OFS_W-1:0];
          state_r  <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= mag * mag;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (window_end) begin
            // the root unit has latched the sum: clear the window
            sum_r   <= '0;
            pos_r   <= '0;
            state_r <= S_ROOT;
          end else begin
            sum_r   <= sum_nxt;
            pos_r   <= pos_nxt;
            state_r <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            rms_r   <= rms_sat;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= rms_r * gain_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the previous result has gone
          if (out_free) begin
            out_rms_r <= rms_r;
            out_cur_r <= cur_sat;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_rms_counts_q8 = out_rms_r;
  assign out_current_ma    = out_cur_r;

endmodule
